/* rtl/assert_macros.svh */
// assertion macros shared by the decoder rtl
// depends on nothing; callers supply clock, reset and message

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define UTDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define UTDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/utdt_pkg.sv */
// shared types, constants and the transliteration table of the utf-8 decoder
// depends on nothing

package utdt_pkg;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;
    localparam int PEND_W = 2;
    localparam int PART_W = 10;

    // continuation bytes still expected
    localparam logic [PEND_W-1:0] PEND_IDLE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              last_unit;
        logic              truncated;
    } unit_t;

    typedef struct packed {
        logic  emit;
        unit_t unit;
    } step_out_t;

    function automatic logic [UNIT_W-1:0] transliterate(input logic [UNIT_W-1:0] v);
        logic [UNIT_W-1:0] r;
        unique case (v)
            16'h0410: r = 16'h0041;
            16'h0412: r = 16'h0042;
            16'h0415: r = 16'h0045;
            16'h041A: r = 16'h004B;
            16'h041C: r = 16'h004D;
            16'h041D: r = 16'h0048;
            16'h041E: r = 16'h004F;
            16'h0420: r = 16'h0050;
            16'h0421: r = 16'h0043;
            16'h0422: r = 16'h0054;
            16'h0425: r = 16'h0058;
            16'h043E: r = 16'h006F;
            16'h00BA: r = 16'h006F;
            16'h0440: r = 16'h0070;
            16'h0441: r = 16'h0063;
            16'h0445: r = 16'h0078;
            16'h0435: r = 16'h0065;
            16'h0430: r = 16'h0061;
            16'h00AA: r = 16'h0061;
            16'h0060: r = 16'h0027;
            default:  r = v;
        endcase
        return r;
    endfunction

endpackage

/* rtl/utf8_decode_transliterate_core.sv */
// Streaming UTF-8 to 16-bit unit decoder with look-alike transliteration.
// One byte enters per request on the in channel (in_byte, is_last); each
// completed character leaves as one request on the out channel (code_unit,
// last_unit, truncated). Lead bytes 110xxxxx and 1110xxxx open two- and
// three-byte sequences; every other byte is decoded as its own value.
// Continuation bytes give no result; the completing byte does.
// A string ending inside a sequence yields a unit with zero-filled missing
// bits and truncated set; the decoder then returns to idle.
// Throughput: one byte per cycle while in_ready is high, set by the single decode stage.
// Results: a completing byte's unit is registered into the output register, or
// into the skid register while the output is held, as the byte is accepted.
// Stall: an output register plus a one-entry skid register sit after the
// decode stage; in_ready drops only while the skid entry is occupied.
// Reset (rst_n low, asynchronous): sequence state cleared, no result held,
// in_ready high once reset is released.
// depends on utdt_pkg, utdt_step and assert_macros.svh

`include "assert_macros.svh"

module utf8_decode_transliterate_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [utdt_pkg::BYTE_W-1:0] in_byte,
    input  logic                        is_last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [utdt_pkg::UNIT_W-1:0] code_unit,
    output logic                        last_unit,
    output logic                        truncated
);
    import utdt_pkg::*;

    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic [PART_W-1:0] partial_reg;
    logic [PART_W-1:0] partial_next;
    step_out_t         step;

    logic  out_valid_reg;
    logic  skid_valid_reg;
    unit_t out_reg;
    unit_t skid_reg;

    logic  in_fire;
    logic  push;
    logic  out_free;

    utdt_step u_step (
        .bytes_pending (pending_reg),
        .partial_value (partial_reg),
        .in_byte       (in_byte),
        .is_last       (is_last),
        .pending_next  (pending_next),
        .partial_next  (partial_next),
        .step          (step)
    );

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign push     = in_fire && step.emit;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= PEND_IDLE;
            partial_reg <= '0;
        end
        else if (in_fire)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= step.unit;
            end
        end
        else if (push)
        begin
            skid_reg <= step.unit;
        end
    end

    assign out_valid = out_valid_reg;
    assign code_unit = out_reg.code_unit;
    assign last_unit = out_reg.last_unit;
    assign truncated = out_reg.truncated;

    `UTDT_ASSERT_IMP(a_skid_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid without output")
    `UTDT_ASSERT_IMP(a_skid_in, clk, rst_n, skid_valid_reg, !in_ready, "ready with skid full")
    `UTDT_ASSERT_IMP(a_trunc, clk, rst_n, out_valid && truncated, last_unit, "truncated not last")
    `UTDT_ASSERT_NXT(a_idle, clk, rst_n, in_fire && is_last, pending_reg == PEND_IDLE, "left open")

endmodule

/* rtl/utdt_step.sv */
// one decode step: running sequence state plus one byte gives next state
// and at most one transliterated unit; depends on utdt_pkg

module utdt_step (
    input  logic [utdt_pkg::PEND_W-1:0] bytes_pending,
    input  logic [utdt_pkg::PART_W-1:0] partial_value,
    input  logic [utdt_pkg::BYTE_W-1:0] in_byte,
    input  logic                        is_last,
    output logic [utdt_pkg::PEND_W-1:0] pending_next,
    output logic [utdt_pkg::PART_W-1:0] partial_next,
    output utdt_pkg::step_out_t         step
);
    import utdt_pkg::*;

    logic              lead2;
    logic              lead3;
    logic [PART_W-1:0] gathered;
    logic [UNIT_W-1:0] value;
    logic              emit;
    logic              trunc;

    assign lead2    = (in_byte & LEAD2_MASK) == LEAD2_TAG;
    assign lead3    = (in_byte & LEAD3_MASK) == LEAD3_TAG;
    assign gathered = {partial_value[3:0], in_byte[5:0]};

    always_comb
    begin
        pending_next = PEND_IDLE;
        partial_next = '0;
        emit         = 1'b1;
        trunc        = 1'b0;
        value        = {{(UNIT_W-BYTE_W){1'b0}}, in_byte};
        unique case (bytes_pending)
            PEND_IDLE:
            begin
                if (lead2)
                begin
                    value = {5'd0, in_byte[4:0], 6'd0};
                    trunc = is_last;
                    emit  = is_last;
                    if (!is_last)
                    begin
                        pending_next = PEND_ONE;
                        partial_next = {5'd0, in_byte[4:0]};
                    end
                end
                else if (lead3)
                begin
                    value = {in_byte[3:0], 12'd0};
                    trunc = is_last;
                    emit  = is_last;
                    if (!is_last)
                    begin
                        pending_next = PEND_TWO;
                        partial_next = {6'd0, in_byte[3:0]};
                    end
                end
            end
            PEND_TWO:
            begin
                value = {gathered, 6'd0};
                trunc = is_last;
                emit  = is_last;
                if (!is_last)
                begin
                    pending_next = PEND_ONE;
                    partial_next = gathered;
                end
            end
            // final continuation byte
            default:
            begin
                value = {partial_value, in_byte[5:0]};
            end
        endcase
    end

    assign step.emit           = emit;
    assign step.unit.code_unit = transliterate(value);
    assign step.unit.last_unit = is_last;
    assign step.unit.truncated = trunc;

endmodule
